// File: hw/rtl/matrix4x4_inverse_macros.svh
// Assertion macros for the 4x4 matrix inverse block.
// Used by the top level only; no other dependencies.
`ifndef MATRIX4X4_INVERSE_MACROS_SVH
`define MATRIX4X4_INVERSE_MACROS_SVH

// same-cycle implication, disabled in reset
`define M4INV_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication, disabled in reset
`define M4INV_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// File: hw/rtl/m4inv_pkg.sv
// Shared types for the 4x4 matrix inverse: datapath opcodes, controller
// states, command/status structs and the cofactor element index function.
package m4inv_pkg;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOADA,
    DP_MUL,
    DP_MOVE,
    DP_CACC,
    DP_CSTORE,
    DP_LOADC,
    DP_DACC,
    DP_DCLR,
    DP_DIVGO,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CLR,
    S_TRI,
    S_CST,
    S_DET,
    S_DIVGO,
    S_DIVW,
    S_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic       wr;
    logic [3:0] waddr;
    logic [3:0] addr;
    logic [2:0] chunk;
    logic       top;
    logic       clr;
    logic       neg;
    logic [3:0] ci;
    logic [3:0] pos;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic singular;
    logic out_free;
  } dp_status_t;

  // column of the minor used by factor j (row j) of product term t
  function automatic logic [1:0] term_col(logic [2:0] t, logic [1:0] j);
    logic [1:0] c;
    c = 2'd0;
    unique case (t)
      3'd0: c = j;
      3'd1: c = (j == 2'd0) ? 2'd1 : (j == 2'd1) ? 2'd2 : 2'd0;
      3'd2: c = (j == 2'd0) ? 2'd2 : (j == 2'd1) ? 2'd0 : 2'd1;
      3'd3: c = (j == 2'd0) ? 2'd0 : (j == 2'd1) ? 2'd2 : 2'd1;
      3'd4: c = (j == 2'd0) ? 2'd1 : (j == 2'd1) ? 2'd0 : 2'd2;
      3'd5: c = (j == 2'd0) ? 2'd2 : (j == 2'd1) ? 2'd1 : 2'd0;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  // store index of factor j of term t in the cofactor of entry k
  function automatic logic [3:0] elem_idx(logic [3:0] k, logic [2:0] t, logic [1:0] j);
    logic [1:0] mc;
    logic [1:0] r;
    logic [1:0] c;
    mc = term_col(t, j);
    r = (j < k[3:2]) ? j : j + 2'd1;
    c = (mc < k[1:0]) ? mc : mc + 2'd1;
    return {r, c};
  endfunction

endpackage

// File: hw/rtl/m4inv_div.sv
// Restoring divider, one quotient bit per cycle, for the matrix inverse.
// Depends on nothing; keeps the low quotient bits plus an overflow flag.
module m4inv_div #(
  parameter int NW = 128,
  parameter int DW = 160,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [QW-1:0] quot,
  output logic          ovf
);

  localparam int CNTW = $clog2(NW);

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   n_r;
  logic [DW-1:0]   d_r;
  logic [DW-1:0]   rem_r;
  logic [QW-1:0]   q_r;
  logic            ovf_r;

  logic [DW:0] rsh;
  logic        qbit;
  logic [DW:0] rdiff;

  always_comb begin
    rsh   = {rem_r, n_r[NW-1]};
    qbit  = (rsh >= {1'b0, d_r});
    rdiff = rsh - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CNTW'(NW - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      cnt_r <= '0;
    end else if (busy_r) begin
      n_r   <= n_r << 1;
      rem_r <= qbit ? rdiff[DW-1:0] : rsh[DW-1:0];
      q_r   <= {q_r[QW-2:0], qbit};
      ovf_r <= ovf_r | q_r[QW-1];
      cnt_r <= cnt_r + CNTW'(1);
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign ovf  = ovf_r;

endmodule

// File: hw/rtl/m4inv_dpath.sv
// Datapath of the matrix inverse: element store, chunked multiplier with
// accumulators, cofactor array, divider and output register. Uses m4inv_pkg.
module m4inv_dpath #(
  parameter int ELEM_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  m4inv_pkg::dp_cmd_t   cmd,
  output m4inv_pkg::dp_status_t status,
  input  logic [31:0]          in_element,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_value,
  output logic [3:0]           out_position,
  output logic                 out_last,
  output logic                 out_singular,
  output logic                 out_clipped
);

  localparam int E  = ELEM_BITS;
  localparam int W  = 5 * ELEM_BITS;
  localparam int NW = 3 * ELEM_BITS + 2 * FRAC_BITS;

  logic [E-1:0]        store_r [16];
  logic signed [W-1:0] cof_r [16];
  logic signed [W-1:0] mx_r;
  logic signed [W-1:0] acc_r;
  logic signed [W-1:0] csum_r;
  logic signed [W-1:0] det_r;
  logic                sign_r;

  logic                 out_valid_r;
  logic signed [31:0]   out_value_r;
  logic [3:0]           out_position_r;
  logic                 out_last_r;
  logic                 out_singular_r;
  logic                 out_clipped_r;

  logic signed [E-1:0]  elem_s;
  logic [E-1:0]         chunk;
  logic signed [E:0]    mop;
  logic signed [2*E:0]  prod;
  logic signed [W-1:0]  acc_nxt;
  logic signed [W-1:0]  cof_sel;
  logic signed [W-1:0]  cof_mag;
  logic signed [W-1:0]  det_mag;
  logic                 singular;
  logic                 div_busy;
  logic [E-1:0]         quot;
  logic                 ovf;
  logic                 clip;
  logic signed [E-1:0]  val_s;

  always_comb begin
    elem_s   = signed'(store_r[cmd.addr]);
    chunk    = mx_r[cmd.chunk * E +: E];
    mop      = signed'({cmd.top & chunk[E-1], chunk});
    prod     = mop * elem_s;
    acc_nxt  = cmd.clr ? W'(prod) : (acc_r <<< E) + W'(prod);
    cof_sel  = cof_r[cmd.ci];
    cof_mag  = cof_sel[W-1] ? -cof_sel : cof_sel;
    det_mag  = det_r[W-1] ? -det_r : det_r;
    singular = (det_r == '0);
  end

  // saturate the quotient magnitude to the signed element range
  always_comb begin
    if (sign_r) begin
      clip = ovf || (quot[E-1] && (quot[E-2:0] != '0));
    end else begin
      clip = ovf || quot[E-1];
    end
    if (clip) begin
      val_s = sign_r ? signed'({1'b1, {(E-1){1'b0}}}) : signed'({1'b0, {(E-1){1'b1}}});
    end else begin
      val_s = sign_r ? -signed'(quot) : signed'(quot);
    end
  end

  m4inv_div #(
    .NW(NW),
    .DW(W),
    .QW(E)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.op == m4inv_pkg::DP_DIVGO),
    .num  ({cof_mag[3*E-1:0], {(2*FRAC_BITS){1'b0}}}),
    .den  (det_mag),
    .busy (div_busy),
    .quot (quot),
    .ovf  (ovf)
  );

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      store_r[cmd.waddr] <= in_element[E-1:0];
    end
    unique case (cmd.op)
      m4inv_pkg::DP_LOADA:  mx_r <= W'(elem_s);
      m4inv_pkg::DP_MUL:    acc_r <= acc_nxt;
      m4inv_pkg::DP_MOVE:   mx_r <= acc_r;
      m4inv_pkg::DP_CACC:   csum_r <= cmd.neg ? csum_r - acc_r : csum_r + acc_r;
      m4inv_pkg::DP_CSTORE: begin
        cof_r[cmd.ci] <= cmd.neg ? -csum_r : csum_r;
        csum_r        <= '0;
      end
      m4inv_pkg::DP_LOADC:  mx_r <= cof_sel;
      m4inv_pkg::DP_DACC:   det_r <= det_r + acc_r;
      m4inv_pkg::DP_DCLR: begin
        csum_r <= '0;
        det_r  <= '0;
      end
      m4inv_pkg::DP_DIVGO:  sign_r <= cof_sel[W-1] ^ det_r[W-1];
      m4inv_pkg::DP_EMIT: begin
        out_value_r    <= singular ? 32'sd0 : 32'(val_s);
        out_clipped_r  <= singular ? 1'b0 : clip;
        out_singular_r <= singular;
        out_position_r <= cmd.pos;
        out_last_r     <= cmd.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == m4inv_pkg::DP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.div_busy = div_busy;
  assign status.singular = singular;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_position = out_position_r;
  assign out_last     = out_last_r;
  assign out_singular = out_singular_r;
  assign out_clipped  = out_clipped_r;

endmodule

// File: hw/rtl/m4inv_ctrl.sv
// Controller of the matrix inverse: sequences loading, cofactor products,
// determinant, divisions and result requests. Uses m4inv_pkg.
module m4inv_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  m4inv_pkg::dp_status_t status,
  output m4inv_pkg::dp_cmd_t    cmd
);

  m4inv_pkg::state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] k_r, k_nxt;
  logic [2:0] t_r, t_nxt;
  logic [2:0] st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= m4inv_pkg::S_LOAD;
      cnt_r   <= '0;
      k_r     <= '0;
      t_r     <= '0;
      st_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      t_r     <= t_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    t_nxt     = t_r;
    st_nxt    = st_r;
    in_stall  = 1'b1;
    cmd       = '0;
    cmd.op    = m4inv_pkg::DP_NOP;
    cmd.waddr = cnt_r;
    cmd.ci    = k_r;
    cmd.pos   = k_r;
    cmd.last  = (k_r == 4'd15);

    unique case (state_r)
      m4inv_pkg::S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.wr  = 1'b1;
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_nxt = m4inv_pkg::S_CLR;
          end
        end
      end
      m4inv_pkg::S_CLR: begin
        cmd.op    = m4inv_pkg::DP_DCLR;
        k_nxt     = '0;
        t_nxt     = '0;
        st_nxt    = '0;
        state_nxt = m4inv_pkg::S_TRI;
      end
      // one product term a*b*c: load a, a*b, move, two chunks times c, then add or subtract it into the cofactor sum
      m4inv_pkg::S_TRI: begin
        st_nxt = st_r + 3'd1;
        unique case (st_r)
          3'd0: begin
            cmd.op   = m4inv_pkg::DP_LOADA;
            cmd.addr = m4inv_pkg::elem_idx(k_r, t_r, 2'd0);
          end
          3'd1: begin
            cmd.op    = m4inv_pkg::DP_MUL;
            cmd.addr  = m4inv_pkg::elem_idx(k_r, t_r, 2'd1);
            cmd.chunk = 3'd0;
            cmd.top   = 1'b1;
            cmd.clr   = 1'b1;
          end
          3'd2: cmd.op = m4inv_pkg::DP_MOVE;
          3'd3: begin
            cmd.op    = m4inv_pkg::DP_MUL;
            cmd.addr  = m4inv_pkg::elem_idx(k_r, t_r, 2'd2);
            cmd.chunk = 3'd1;
            cmd.top   = 1'b1;
            cmd.clr   = 1'b1;
          end
          3'd4: begin
            cmd.op    = m4inv_pkg::DP_MUL;
            cmd.addr  = m4inv_pkg::elem_idx(k_r, t_r, 2'd2);
            cmd.chunk = 3'd0;
          end
          default: begin
            cmd.op = m4inv_pkg::DP_CACC;
            cmd.neg = (t_r >= 3'd3);
            st_nxt  = '0;
            t_nxt   = t_r + 3'd1;
            if (t_r == 3'd5) begin
              state_nxt = m4inv_pkg::S_CST;
            end
          end
        endcase
      end
      m4inv_pkg::S_CST: begin
        cmd.op  = m4inv_pkg::DP_CSTORE;
        cmd.neg = k_r[2] ^ k_r[0];
        t_nxt   = '0;
        st_nxt  = '0;
        k_nxt   = k_r + 4'd1;
        state_nxt = (k_r == 4'd15) ? m4inv_pkg::S_DET : m4inv_pkg::S_TRI;
      end
      // first-row cofactor times element, cofactor taken in four chunks
      m4inv_pkg::S_DET: begin
        st_nxt   = st_r + 3'd1;
        cmd.addr = k_r;
        unique case (st_r)
          3'd0: cmd.op = m4inv_pkg::DP_LOADC;
          3'd1, 3'd2, 3'd3, 3'd4: begin
            cmd.op    = m4inv_pkg::DP_MUL;
            cmd.chunk = 3'd4 - st_r;
            cmd.top   = (st_r == 3'd1);
            cmd.clr   = (st_r == 3'd1);
          end
          default: begin
            cmd.op = m4inv_pkg::DP_DACC;
            st_nxt = '0;
            k_nxt  = k_r + 4'd1;
            if (k_r == 4'd3) begin
              k_nxt     = '0;
              state_nxt = m4inv_pkg::S_DIVGO;
            end
          end
        endcase
      end
      m4inv_pkg::S_DIVGO: begin
        cmd.ci = {k_r[1:0], k_r[3:2]};
        if (status.singular) begin
          state_nxt = m4inv_pkg::S_EMIT;
        end else begin
          cmd.op    = m4inv_pkg::DP_DIVGO;
          state_nxt = m4inv_pkg::S_DIVW;
        end
      end
      m4inv_pkg::S_DIVW: begin
        if (!status.div_busy) begin
          state_nxt = m4inv_pkg::S_EMIT;
        end
      end
      m4inv_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.op = m4inv_pkg::DP_EMIT;
          k_nxt  = k_r + 4'd1;
          state_nxt = (k_r == 4'd15) ? m4inv_pkg::S_LOAD : m4inv_pkg::S_DIVGO;
        end
      end
      default: state_nxt = m4inv_pkg::S_LOAD;
    endcase
  end

endmodule

// File: hw/rtl/matrix4x4_inverse.sv
// 4x4 matrix inverse by the adjugate. Sixteen signed Q elements are taken
// row-major, one per request, at one per cycle; the block then stalls its
// input, works the sixteen cofactors and the determinant on one chunked
// multiplier and divides on a one-bit-per-cycle restoring divider of
// 3*ELEM_BITS+2*FRAC_BITS steps per result. Results come row-major with
// position, last, singular and clipped flags.
`include "matrix4x4_inverse_macros.svh"

module matrix4x4_inverse #(
  parameter int ELEM_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_element,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [3:0]         out_position,
  output logic               out_last,
  output logic               out_singular,
  output logic               out_clipped
);

  m4inv_pkg::dp_cmd_t    cmd;
  m4inv_pkg::dp_status_t status;

  m4inv_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  m4inv_dpath #(
    .ELEM_BITS(ELEM_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_element  (in_element),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .out_position(out_position),
    .out_last    (out_last),
    .out_singular(out_singular),
    .out_clipped (out_clipped)
  );

  `M4INV_ASSERT_IMP(a_last_pos, clk, rst_n, out_valid && out_last, out_position == 4'hF, "last not at position 15")
  `M4INV_ASSERT_IMP(a_sing_zero, clk, rst_n, out_valid && out_singular, out_value == 32'sd0 && !out_clipped, "singular result not zero")
  `M4INV_ASSERT_IMP(a_load_idle, clk, rst_n, in_valid && !in_stall, !status.div_busy, "load while dividing")

endmodule

// File: tb/sv/m4inv_checker.sv
`timescale 1ns / 1ps
// Result checker for matrix4x4_inverse: watches both channels, predicts the
// inverse of every loaded matrix by exact adjugate arithmetic and compares.
// Standalone; no dependency beyond the block's port list.
module m4inv_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [31:0]        in_element,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_value,
  input  logic [3:0]         out_position,
  input  logic               out_last,
  input  logic               out_singular,
  input  logic               out_clipped,
  output int                 fail_count,
  output int                 pending
);

  localparam int FRAC = 16;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic signed [31:0] value;
    logic [3:0]         position;
    logic               last;
    logic               singular;
    logic               clipped;
  } inv_elem_t;

  logic [31:0] mat_store [16];
  logic [3:0]  load_slot;
  inv_elem_t   inverse_q[$];

  function automatic wide_t entry(int idx);
    return wide_t'($signed(mat_store[idx]));
  endfunction

  // signed cofactor of (sr, sc)
  function automatic wide_t cofactor(int sr, int sc);
    int    rows[3];
    int    cols[3];
    int    n;
    wide_t e[3][3];
    wide_t acc;
    n = 0;
    for (int i = 0; i < 4; i++) if (i != sr) begin rows[n] = i; n++; end
    n = 0;
    for (int i = 0; i < 4; i++) if (i != sc) begin cols[n] = i; n++; end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) e[i][j] = entry(rows[i] * 4 + cols[j]);
    acc = e[0][0] * e[1][1] * e[2][2] + e[0][1] * e[1][2] * e[2][0]
        + e[0][2] * e[1][0] * e[2][1] - e[0][0] * e[1][2] * e[2][1]
        - e[0][1] * e[1][0] * e[2][2] - e[0][2] * e[1][1] * e[2][0];
    return ((sr + sc) % 2 == 1) ? -acc : acc;
  endfunction

  task automatic predict_inverse();
    wide_t       cof[16];
    wide_t       det;
    logic [191:0] dmag;
    logic [191:0] nmag;
    logic [191:0] q;
    logic [191:0] bound;
    logic        neg;
    inv_elem_t   r;
    det = 0;
    for (int k = 0; k < 16; k++) cof[k] = cofactor(k / 4, k % 4);
    for (int k = 0; k < 4; k++) det += cof[k] * entry(k);
    dmag = det < 0 ? -det : det;
    for (int k = 0; k < 16; k++) begin
      r.position = k[3:0];
      r.last = (k == 15);
      r.singular = (det == 0);
      r.clipped = 1'b0;
      r.value = '0;
      if (det != 0) begin
        neg = (cof[(k % 4) * 4 + k / 4] < 0) != (det < 0);
        nmag = cof[(k % 4) * 4 + k / 4] < 0 ? -cof[(k % 4) * 4 + k / 4]
                                              : cof[(k % 4) * 4 + k / 4];
        q = (nmag << (2 * FRAC)) / dmag;
        bound = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
        if (q > bound) begin
          q = bound;
          r.clipped = 1'b1;
        end
        r.value = neg ? -q[31:0] : q[31:0];
      end
      inverse_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    inv_elem_t x;
    if (!rst_n) begin
      load_slot <= '0;
      fail_count <= 0;
      pending <= 0;
      inverse_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (inverse_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("%0t: unexpected result pos %0d value %h", $realtime,
                     out_position, out_value);
        end else begin
          x = inverse_q.pop_front();
          if (out_value !== x.value || out_position !== x.position ||
              out_last !== x.last || out_singular !== x.singular ||
              out_clipped !== x.clipped) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("%0t: mismatch exp v=%h p=%0d l=%b s=%b c=%b got v=%h p=%0d l=%b s=%b c=%b",
                       $realtime, x.value, x.position, x.last, x.singular, x.clipped,
                       out_value, out_position, out_last, out_singular, out_clipped);
          end
        end
      end
      if (in_valid && !in_stall) begin
        mat_store[load_slot] = in_element;
        load_slot <= load_slot + 4'd1;
        if (load_slot == 4'd15) predict_inverse();
      end
      pending <= inverse_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the matrix4x4_inverse testbench: clock, reset, request stimulus and
// result-side stalling; checking lives in m4inv_checker.
module tb_top;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [31:0]        in_element;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_value;
  logic [3:0]         out_position;
  logic               out_last;
  logic               out_singular;
  logic               out_clipped;
  int                 fail_count;
  int                 pending;
  bit                 calm;
  bit                 hold_req;

  matrix4x4_inverse dut (.*);

  m4inv_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_element(logic [31:0] v);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_matrix(logic [31:0] m[16]);
    for (int i = 0; i < 16; i++) send_element(m[i]);
  endtask

  function automatic logic [31:0] pick_extreme();
    unique case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'h1;
      4: return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  initial begin
    logic [31:0] m[16];
    int          kind;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_element = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tiny diagonal: every diagonal quotient saturates, one of them negative
    for (int i = 0; i < 16; i++) m[i] = '0;
    m[0] = 32'h1; m[5] = 32'hFFFF_FFFF; m[10] = 32'h1; m[15] = 32'h1;
    send_matrix(m);
    // all zero: singular
    for (int i = 0; i < 16; i++) m[i] = '0;
    send_matrix(m);

    for (int n = 0; n < 18; n++) begin
      if (n == 2) hold_req = 1'b1;
      if (n == 14) calm = 1'b1;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 16; i++) begin
        if (kind < 4)
          m[i] = (i % 5 == 0) ? (($urandom_range(0, 1) ? -32'sd1 : 32'sd1)
                                 * $urandom_range(32768, 262144))
                              : $urandom_range(0, 40000) - 20000;
        else if (kind < 6)
          m[i] = $urandom;
        else if (kind < 8)
          m[i] = pick_extreme();
        else
          m[i] = $urandom_range(0, 14) - 7;
      end
      // duplicated row makes the matrix singular
      if (kind == 3 || kind == 9)
        for (int c = 0; c < 4; c++) m[12 + c] = m[4 + c];
      send_matrix(m);
    end
    in_valid <= 1'b0;

    // let the checker see the last request before looking at its queue
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
